>>> rtl/bmhpq_pkg.sv
// Shared types and constants for the binary min-heap priority queue.
package bmhpq_pkg;

    localparam int DATA_W           = 32;
    localparam int COUNT_W          = 11;
    localparam int DEFAULT_CAPACITY = 1024;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // One heap slot: element and its priority.
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] pri;
    } entry_t;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_priority;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic signed [DATA_W-1:0] removed_priority;
        logic signed [DATA_W-1:0] head_value;
        logic signed [DATA_W-1:0] head_priority;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        status_t                  status;
    } result_t;

endpackage

>>> rtl/binary_min_heap_priority_queue.sv
// Binary min-heap priority queue of (element, priority) pairs held in one block RAM.
//
// Input channel s_*: one transaction is an insert (element, priority) or a remove of
// a minimum-priority entry. Result channel m_*: exactly one transaction per input,
// carrying the removed pair, the new head, the entry count and a status code.
// Smaller priorities are served first; equal priorities keep the older position
// on sift-up, and the left child wins a tie on sift-down.
//
// The heap lives in a RAM of CAPACITY slots with one write port and two
// registered read ports; a register shadows the root. Each level of a sift
// issues a read, then compares and writes back. One item is worked on at a
// time; a new item is taken while the previous result waits in the output
// register. If the receiver stalls with a result pending, the next finished
// result holds in place until the output register frees up.
//
// Reset (aresetn low, synchronous) empties the queue at once; the RAM contents
// are not cleared, since only slots up to the count are ever used.
module binary_min_heap_priority_queue #(
    parameter int CAPACITY = bmhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bmhpq_pkg::in_item_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bmhpq_pkg::result_t  m_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = CW + 1;
    localparam logic [CW-1:0] CAP_SLOTS = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE       = CW'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_LAST,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          pos_reg, pos_next;
    bmhpq_pkg::entry_t      x_reg, x_next;
    bmhpq_pkg::entry_t      root_reg, root_next;
    bmhpq_pkg::entry_t      rem_reg, rem_next;
    bmhpq_pkg::status_t     status_reg, status_next;
    logic                   m_valid_reg, m_valid_next;
    bmhpq_pkg::result_t     m_data_reg, m_data_next;

    // Heap RAM: slot k sits at address k-1.
    bmhpq_pkg::entry_t      heap_mem [CAPACITY];
    bmhpq_pkg::entry_t      rd_a_reg, rd_b_reg;
    logic                   we;
    logic [AW-1:0]          waddr, raddr_a, raddr_b;
    bmhpq_pkg::entry_t      wdata;

    logic [LW-1:0]          left_slot;
    logic                   right_ok, pick_right;
    bmhpq_pkg::entry_t      kid;
    logic [LW-1:0]          kid_slot;
    logic                   accept;

    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[waddr] <= wdata;
        end
        rd_a_reg <= heap_mem[raddr_a];
        rd_b_reg <= heap_mem[raddr_b];
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign left_slot = {pos_reg, 1'b0};
    assign right_ok  = left_slot < LW'(count_reg);
    assign pick_right = right_ok && (rd_a_reg.pri > rd_b_reg.pri);
    assign kid       = pick_right ? rd_b_reg : rd_a_reg;
    assign kid_slot  = pick_right ? (left_slot + LW'(1)) : left_slot;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        x_next       = x_reg;
        root_next    = root_reg;
        rem_next     = rem_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        we           = 1'b0;
        waddr        = AW'(pos_reg - ONE);
        wdata        = x_reg;
        raddr_a      = '0;
        raddr_b      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rem_next    = '0;
                    status_next = bmhpq_pkg::STATUS_OK;
                    if (s_data.opcode == bmhpq_pkg::OP_INSERT) begin
                        if (count_reg == CAP_SLOTS) begin
                            status_next = bmhpq_pkg::STATUS_FULL;
                            state_next  = ST_DONE;
                        end else begin
                            count_next = count_reg + ONE;
                            pos_next   = count_reg + ONE;
                            x_next.val = s_data.item_value;
                            x_next.pri = s_data.item_priority;
                            state_next = ST_UP_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = bmhpq_pkg::STATUS_EMPTY;
                            state_next  = ST_DONE;
                        end else begin
                            rem_next   = root_reg;
                            count_next = count_reg - ONE;
                            // fetch the last slot to refill the root
                            raddr_a    = AW'(count_reg - ONE);
                            state_next = (count_reg == ONE) ? ST_DONE : ST_DN_LAST;
                        end
                    end
                end
            end

            ST_UP_RD: begin
                if (pos_reg == ONE) begin
                    we         = 1'b1;
                    root_next  = x_reg;
                    state_next = ST_DONE;
                end else begin
                    raddr_a    = AW'((pos_reg >> 1) - ONE);
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP: begin
                we = 1'b1;
                if (rd_a_reg.pri > x_reg.pri) begin
                    // move the parent down into the hole
                    wdata      = rd_a_reg;
                    pos_next   = pos_reg >> 1;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_DN_LAST: begin
                x_next     = rd_a_reg;
                pos_next   = ONE;
                state_next = ST_DN_RD;
            end

            ST_DN_RD: begin
                if (left_slot > LW'(count_reg)) begin
                    we = 1'b1;
                    if (pos_reg == ONE) begin
                        root_next = x_reg;
                    end
                    state_next = ST_DONE;
                end else begin
                    raddr_a    = AW'(left_slot - LW'(1));
                    raddr_b    = AW'(left_slot);
                    state_next = ST_DN_CMP;
                end
            end

            ST_DN_CMP: begin
                we = 1'b1;
                if (x_reg.pri > kid.pri) begin
                    // lift the smaller child into the hole
                    wdata = kid;
                    if (pos_reg == ONE) begin
                        root_next = kid;
                    end
                    pos_next   = CW'(kid_slot);
                    state_next = ST_DN_RD;
                end else begin
                    if (pos_reg == ONE) begin
                        root_next = x_reg;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                 = 1'b1;
                    m_data_next.removed_value    = rem_reg.val;
                    m_data_next.removed_priority = rem_reg.pri;
                    m_data_next.head_value       = (count_reg != '0) ? root_reg.val : '0;
                    m_data_next.head_priority    = (count_reg != '0) ? root_reg.pri : '0;
                    m_data_next.entry_count      = bmhpq_pkg::COUNT_W'(count_reg);
                    m_data_next.is_empty         = (count_reg == '0);
                    m_data_next.status           = status_reg;
                    state_next                   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg    <= pos_next;
        x_reg      <= x_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_SLOTS)
        else $error("heap count above capacity");

    a_write_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (pos_reg != '0) && (pos_reg <= count_reg))
        else $error("heap write outside occupied slots");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_data.opcode == bmhpq_pkg::OP_REMOVE) && (count_reg != '0)
        |=> count_reg == $past(count_reg) - ONE)
        else $error("remove did not drop the count");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.status == bmhpq_pkg::STATUS_FULL)
        |-> m_data_reg.entry_count == bmhpq_pkg::COUNT_W'(CAPACITY))
        else $error("full status reported below capacity");

    a_sink_has_child: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DN_CMP) |-> left_slot <= LW'(count_reg))
        else $error("sift-down compare without a child");

endmodule

>>> tb/sv/heap_result_checker.sv
// Result checker for the binary min-heap priority queue: shadow heap, expected queue, compare.
`timescale 1ns / 1ps

module heap_result_checker #(
    parameter int CAPACITY = bmhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  bmhpq_pkg::in_item_t s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  bmhpq_pkg::result_t  m_data,
    output int                  mismatch_total,
    output int                  outstanding,
    output int                  results_checked
);
    import bmhpq_pkg::*;

    entry_t  shadow_heap [1:CAPACITY];
    int      shadow_fill = 0;
    result_t expected_results [$];
    int      mismatches = 0;
    int      checked = 0;

    function automatic bit pri_above(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

    function automatic void swap_slots(input int a, input int b);
        entry_t carry;
        carry          = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = carry;
    endfunction

    // Apply one queue operation to the shadow heap and return the result it should produce.
    function automatic result_t apply_heap_op(input in_item_t op_item);
        result_t outcome;
        int      pos;
        int      next;
        outcome        = '0;
        outcome.status = STATUS_OK;
        if (op_item.opcode == OP_INSERT) begin
            if (shadow_fill >= CAPACITY) begin
                outcome.status = STATUS_FULL;
            end else begin
                shadow_fill++;
                shadow_heap[shadow_fill].val = op_item.item_value;
                shadow_heap[shadow_fill].pri = op_item.item_priority;
                pos = shadow_fill;
                // stop at a parent of equal priority
                while (pos > 1) begin
                    next = pos / 2;
                    if (!pri_above(shadow_heap[next].pri, shadow_heap[pos].pri))
                        break;
                    swap_slots(pos, next);
                    pos = next;
                end
            end
        end else if (shadow_fill == 0) begin
            outcome.status = STATUS_EMPTY;
        end else begin
            outcome.removed_value    = shadow_heap[1].val;
            outcome.removed_priority = shadow_heap[1].pri;
            shadow_heap[1] = shadow_heap[shadow_fill];
            shadow_fill--;
            pos = 1;
            while (2 * pos <= shadow_fill) begin
                next = 2 * pos;
                // left child wins a tie
                if (next < shadow_fill && pri_above(shadow_heap[next].pri, shadow_heap[next + 1].pri))
                    next++;
                if (!pri_above(shadow_heap[pos].pri, shadow_heap[next].pri))
                    break;
                swap_slots(pos, next);
                pos = next;
            end
        end
        if (shadow_fill != 0) begin
            outcome.head_value    = shadow_heap[1].val;
            outcome.head_priority = shadow_heap[1].pri;
        end
        outcome.entry_count = shadow_fill[COUNT_W-1:0];
        outcome.is_empty    = (shadow_fill == 0);
        return outcome;
    endfunction

    task automatic note_field(input string field, input longint want_v, input longint got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want_v, got_v);
    endtask

    always @(posedge aclk) begin : compare_proc
        result_t want;
        if (!aresetn) begin
            expected_results.delete();
            shadow_fill = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transaction with nothing outstanding", $realtime);
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (m_data.removed_value !== want.removed_value)
                        note_field("removed_value", want.removed_value, m_data.removed_value);
                    if (m_data.removed_priority !== want.removed_priority)
                        note_field("removed_priority", want.removed_priority,
                                   m_data.removed_priority);
                    if (m_data.head_value !== want.head_value)
                        note_field("head_value", want.head_value, m_data.head_value);
                    if (m_data.head_priority !== want.head_priority)
                        note_field("head_priority", want.head_priority, m_data.head_priority);
                    if (m_data.entry_count !== want.entry_count)
                        note_field("entry_count", want.entry_count, m_data.entry_count);
                    if (m_data.is_empty !== want.is_empty)
                        note_field("is_empty", want.is_empty, m_data.is_empty);
                    if (m_data.status !== want.status)
                        note_field("status", want.status, m_data.status);
                end
            end
            // queue the prediction behind everything still outstanding
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(), apply_heap_op(s_data));
        end
        mismatch_total  <= mismatches;
        outstanding     <= expected_results.size();
        results_checked <= checked;
    end

endmodule

>>> tb/sv/tb_binary_min_heap_priority_queue.sv
// Testbench top for the binary min-heap priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_binary_min_heap_priority_queue;
    import bmhpq_pkg::*;

    localparam int CAPACITY    = DEFAULT_CAPACITY;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    in_item_t s_data;
    logic     m_valid;
    logic     m_ready;
    result_t  m_data;

    int mismatch_count;
    int pending_count;
    int checked_count;

    bit sender_gaps     = 1'b0;
    bit receiver_stalls = 1'b0;
    int hold_requests   = 0;
    int quiet_cycles    = 0;

    // occupancy as seen by the sender, used to steer the stimulus and for the summary
    int queue_level   = 0;
    int peak_level    = 0;
    int sent_count    = 0;
    int full_refusals = 0;
    int empty_removes = 0;

    binary_min_heap_priority_queue #(.CAPACITY(CAPACITY)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    heap_result_checker #(.CAPACITY(CAPACITY)) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_total  (mismatch_count),
        .outstanding     (pending_count),
        .results_checked (checked_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
            $display("binary_min_heap_priority_queue verification failed");
            $finish;
        end
    end

    // Result side: long hold-offs on request, short random stalls when enabled.
    initial begin : receiver
        int holds_served;
        holds_served = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] boundary_word();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4:       return 32'sh8000_0001;
            default: return 32'sh7fff_fffe;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        if ($urandom_range(0, 7) == 0)
            return boundary_word();
        return $urandom;
    endfunction

    // Favor a narrow band so that equal priorities are common.
    function automatic logic signed [DATA_W-1:0] random_prio();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom_range(0, 15)) - 8;
            4, 5:       return boundary_word();
            default:    return $urandom;
        endcase
    endfunction

    task automatic offer_item(input logic op, input logic signed [DATA_W-1:0] elem,
                              input logic signed [DATA_W-1:0] prio);
        in_item_t next_item;
        next_item.opcode        = op;
        next_item.item_value    = elem;
        next_item.item_priority = prio;
        s_valid <= 1'b1;
        s_data  <= next_item;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (op == OP_INSERT) begin
            if (queue_level >= CAPACITY)
                full_refusals++;
            else
                queue_level++;
        end else begin
            if (queue_level == 0)
                empty_removes++;
            else
                queue_level--;
        end
        if (queue_level > peak_level)
            peak_level = queue_level;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic insert_item(input logic signed [DATA_W-1:0] elem,
                               input logic signed [DATA_W-1:0] prio);
        offer_item(OP_INSERT, elem, prio);
    endtask

    task automatic remove_min();
        offer_item(OP_REMOVE, $urandom, $urandom);
    endtask

    // Hold the input low until every outstanding result has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic run_mixed(input int count, input int insert_pct, input bit allow_idle);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                sender_gaps     = allow_idle && ($urandom_range(0, 2) != 0);
                receiver_stalls = allow_idle && ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 99) < insert_pct)
                insert_item(random_value(), random_prio());
            else
                remove_min();
        end
    endtask

    initial begin : stimulus
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty removal, extremes, equal priorities, drain to empty
        remove_min();
        insert_item(32'sd11, 32'sd0);
        insert_item(32'sh7fff_ffff, 32'sh7fff_ffff);
        insert_item(32'sh8000_0000, 32'sh8000_0000);
        insert_item(-32'sd1, -32'sd1);
        insert_item(32'sd21, 32'sd0);
        insert_item(32'sd22, 32'sd0);
        insert_item(32'sd0, 32'sh7fff_ffff);
        repeat (7) remove_min();
        remove_min();
        for (int k = 1; k <= 4; k++)
            insert_item(k, 32'sd5);
        repeat (5) remove_min();
        wait_for_results();

        run_mixed(300, 60, 1'b1);
        wait_for_results();

        // start a long result-side hold-off, fill to capacity, then push past full
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        hold_requests <= hold_requests + 1;
        while (queue_level < CAPACITY)
            insert_item(random_value(), random_prio());
        repeat (6) insert_item(random_value(), random_prio());
        run_mixed(60, 70, 1'b1);
        wait_for_results();

        run_mixed(150, 35, 1'b1);
        run_mixed(150, 40, 1'b0);
        wait_for_results();
        repeat (40) @(posedge aclk);

        $display("%0d operations sent, %0d results checked, peak occupancy %0d of %0d",
                 sent_count, checked_count, peak_level, CAPACITY);
        $display("%0d inserts refused on a full queue, %0d removes on an empty queue",
                 full_refusals, empty_removes);
        if (mismatch_count == 0)
            $display("binary_min_heap_priority_queue verification clean");
        else
            $display("binary_min_heap_priority_queue verification failed");
        $finish;
    end

endmodule
